>>> rtl/strs_pkg.sv
// Shared types and constants for the segment tree range-sum core.
// Used by strs_mem and segment_tree_range_sum_core; depends on nothing else.
package strs_pkg;

   localparam int LEAF_BITS = 10;
   localparam int LEAVES    = 1 << LEAF_BITS;
   localparam int NODE_AW   = LEAF_BITS + 1;
   localparam int NODES     = 1 << NODE_AW;
   localparam int DATA_W    = 32;
   localparam int LEN_W     = 11;
   localparam int BOUND_W   = NODE_AW + 1;

   localparam logic [LEN_W-1:0]   LEN_RESET  = LEN_W'(LEAVES);
   localparam logic [LEN_W-1:0]   LEN_MAX    = LEN_W'(LEAVES);
   localparam logic [NODE_AW-1:0] ROOT_NODE  = NODE_AW'(1);
   localparam logic [NODE_AW-1:0] LAST_NODE  = NODE_AW'(NODES - 1);

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   typedef enum logic [5:0] {
      S_CLEAR   = 6'b000001,
      S_IDLE    = 6'b000010,
      S_UPD_RD  = 6'b000100,
      S_UPD_WR  = 6'b001000,
      S_QRY     = 6'b010000,
      S_DONE    = 6'b100000
   } state_type;

   typedef struct packed {
      logic               en;
      logic [NODE_AW-1:0] addr;
      logic [DATA_W-1:0]  data;
   } mem_wr_type;

endpackage

>>> rtl/segment_tree_range_sum_core.sv
// Top level of the segment tree range-sum core with point update.
// Depends on strs_pkg and instantiates the node memory strs_mem.

// The core keeps 32-bit wrapping sums over 1024 elements in a heap-ordered
// binary tree held in one synchronous memory (node 1 is the root, element i
// sits at node 1024 + i). After reset the core runs a clearing pass, one
// memory entry per cycle, and holds req_stall high meanwhile; csr writes are
// taken at any time. One request is worked on at a time. An update reads the
// old leaf and then walks from the leaf to the root with a read and a write
// per level. A query walks both range bounds upward and adds the nodes it
// reads. Invalid requests go straight to the response. The result sits in an
// output register, so the next request is accepted while the previous
// response still waits for the consumer.
module segment_tree_range_sum_core
   import strs_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_command,
   input  logic        [LEAF_BITS-1:0] req_range_start,
   input  logic        [LEAF_BITS-1:0] req_range_end,
   input  logic signed [DATA_W-1:0]    req_value,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [DATA_W-1:0]    rsp_sum,
   output logic                        rsp_status,

   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic        [LEN_W-1:0]     csr_active_length
);

   state_type           state_ff, state_in;
   logic [LEN_W-1:0]    length_ff;
   logic [NODE_AW-1:0]  clear_ff, clear_in;

   // Update walk: current node, new value, difference to add on the path.
   logic [NODE_AW-1:0]  node_ff, node_in;
   logic [DATA_W-1:0]   value_ff, value_in;
   logic [DATA_W-1:0]   diff_ff, diff_in;
   logic                leaf_ff, leaf_in;

   // Query walk: half-open bounds in node numbering and the running sum.
   logic [BOUND_W-1:0]  lo_ff, lo_in;
   logic [BOUND_W-1:0]  hi_ff, hi_in;
   logic [DATA_W-1:0]   acc_ff, acc_in;
   logic                pend_ff, pend_in;
   logic                status_ff, status_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_sum_ff, rsp_sum_in;
   logic                rsp_status_ff, rsp_status_in;

   mem_wr_type          mem_wr;
   logic [NODE_AW-1:0]  rd_addr;
   logic [DATA_W-1:0]   rd_data;

   logic [LEN_W-1:0]    eff_len;
   logic                req_fire;
   logic                bad_update;
   logic                bad_query;
   logic [DATA_W-1:0]   diff_now;
   logic [DATA_W-1:0]   acc_sum;
   logic [BOUND_W-1:0]  hi_dec;
   logic                out_free;

   strs_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;

   // Lengths above the number of leaves behave as the full tree.
   assign eff_len    = (length_ff > LEN_MAX) ? LEN_MAX : length_ff;
   assign bad_update = ({1'b0, req_range_start} >= eff_len);
   assign bad_query  = ({1'b0, req_range_end} >= eff_len) ||
                       (req_range_start > req_range_end);

   // At the leaf the difference is formed from the old value just read.
   assign diff_now = leaf_ff ? (value_ff - rd_data) : diff_ff;
   assign acc_sum  = acc_ff + (pend_ff ? rd_data : '0);
   assign hi_dec   = hi_ff - BOUND_W'(1);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (state_ff)
         S_UPD_RD: rd_addr = node_ff;
         S_QRY:    rd_addr = lo_ff[0] ? lo_ff[NODE_AW-1:0] : hi_dec[NODE_AW-1:0];
         default:  rd_addr = node_ff;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      clear_in      = clear_ff;
      node_in       = node_ff;
      value_in      = value_ff;
      diff_in       = diff_ff;
      leaf_in       = leaf_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      acc_in        = acc_ff;
      pend_in       = pend_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sum_in    = rsp_sum_ff;
      rsp_status_in = rsp_status_ff;
      mem_wr.en     = 1'b0;
      mem_wr.addr   = node_ff;
      mem_wr.data   = rd_data + diff_now;

      case (state_ff)
         S_CLEAR: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = clear_ff;
            mem_wr.data = '0;
            clear_in    = clear_ff + NODE_AW'(1);
            if (clear_ff == LAST_NODE) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               acc_in    = '0;
               pend_in   = 1'b0;
               status_in = STATUS_OK;
               node_in   = {1'b1, req_range_start};
               value_in  = DATA_W'(req_value);
               leaf_in   = 1'b1;
               lo_in     = BOUND_W'({1'b1, req_range_start});
               hi_in     = BOUND_W'({1'b1, req_range_end}) + BOUND_W'(1);
               if (req_command == CMD_UPDATE) begin
                  if (bad_update) begin
                     status_in = STATUS_INVALID;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_UPD_RD;
                  end
               end else begin
                  if (bad_query) begin
                     status_in = STATUS_INVALID;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_QRY;
                  end
               end
            end
         end
         S_UPD_RD: begin
            state_in = S_UPD_WR;
         end
         S_UPD_WR: begin
            // Add the difference to this node, then move to its parent.
            mem_wr.en = 1'b1;
            diff_in   = diff_now;
            leaf_in   = 1'b0;
            node_in   = node_ff >> 1;
            if (node_ff == ROOT_NODE) begin
               state_in = S_DONE;
            end else begin
               state_in = S_UPD_RD;
            end
         end
         S_QRY: begin
            // The node read in the previous cycle is folded in here.
            acc_in = acc_sum;
            if (lo_ff >= hi_ff) begin
               pend_in  = 1'b0;
               state_in = S_DONE;
            end else if (lo_ff[0]) begin
               lo_in   = lo_ff + BOUND_W'(1);
               pend_in = 1'b1;
            end else if (hi_ff[0]) begin
               hi_in   = hi_dec;
               pend_in = 1'b1;
            end else begin
               lo_in   = lo_ff >> 1;
               hi_in   = hi_ff >> 1;
               pend_in = 1'b0;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sum_in    = (status_ff == STATUS_OK) ? acc_ff : '0;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_ff     <= '0;
         length_ff    <= LEN_RESET;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         if (csr_valid && csr_ready) begin
            length_ff <= csr_active_length;
         end
      end
   end

   always_ff @(posedge clock) begin
      node_ff       <= node_in;
      value_ff      <= value_in;
      diff_ff       <= diff_in;
      leaf_ff       <= leaf_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      acc_ff        <= acc_in;
      status_ff     <= status_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sum    = rsp_sum_ff;
   assign rsp_status = rsp_status_ff;

endmodule

>>> rtl/strs_mem.sv
// Node storage for the segment tree: one write port, one registered read port.
// Depends on strs_pkg for widths and the write port struct.
module strs_mem
   import strs_pkg::*;
(
   input  logic               clock,
   input  mem_wr_type         wr,
   input  logic [NODE_AW-1:0] rd_addr,
   output logic [DATA_W-1:0]  rd_data
);

   logic [DATA_W-1:0] tree_ff [NODES];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         tree_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= tree_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/tb_segment_tree_range_sum_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for segment_tree_range_sum_core: a directed table and random phases.
// Depends on strs_pkg and the core RTL. It keeps its own model of the element array.
module tb_segment_tree_range_sum_core;
   import strs_pkg::*;

   // The run is stopped here at the latest. The slowest correct run is about 630 requests
   // plus the clearing pass, so this leaves ample margin.
   localparam int CYCLE_LIMIT   = 200_000;
   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES    = 64;
   localparam int PHASE_COUNT   = 6;
   localparam int PHASE_ITEMS   = 100;

   // A response sum and its status, as the core reports them for one request.
   typedef struct packed {
      logic [DATA_W-1:0] sum;
      logic              status;
   } range_result_type;

   typedef enum logic {ROW_REQUEST, ROW_LENGTH} row_kind_type;

   // One line of the directed script. A ROW_LENGTH line programs active_length.
   // Where typed is set, the expected response is given in the row and not predicted.
   typedef struct packed {
      row_kind_type      kind;
      logic [LEN_W-1:0]  length;
      logic              command;
      logic [9:0]        first_idx;
      logic [9:0]        last_idx;
      logic [DATA_W-1:0] value;
      logic              typed;
      logic [DATA_W-1:0] exp_sum;
      logic              exp_status;
   } script_row_type;

   localparam int SCRIPT_ROWS = 29;
   localparam script_row_type SCRIPT [SCRIPT_ROWS] = '{
      // The tree is all zero after reset, and the default length spans every element.
      '{ROW_REQUEST, 11'd0, CMD_QUERY, 10'd0, 10'd1023, 32'd0, 1'b1, 32'd0, STATUS_OK},
      // The extreme values go to the extreme indices, then get overwritten so the sums wrap.
      '{ROW_REQUEST, 11'd0, CMD_UPDATE, 10'd0, 10'd0, 32'h7fff_ffff, 1'b0, 32'd0, STATUS_OK},
      '{ROW_REQUEST, 11'd0, CMD_UPDATE, 10'd1023, 10'd0, 32'h8000_0000, 1'b0, 32'd0, STATUS_OK},
      '{ROW_REQUEST, 11'd0, CMD_QUERY, 10'd0, 10'd1023, 32'd0, 1'b0, 32'd0, STATUS_OK},
      '{ROW_REQUEST, 11'd0, CMD_UPDATE, 10'd0, 10'd1023, 32'hffff_ffff, 1'b0, 32'd0, STATUS_OK},
      '{ROW_REQUEST, 11'd0, CMD_UPDATE, 10'd1023, 10'd0, 32'h7fff_ffff, 1'b0, 32'd0, STATUS_OK},
      '{ROW_REQUEST, 11'd0, CMD_QUERY, 10'd0, 10'd0, 32'd0, 1'b0, 32'd0, STATUS_OK},
      '{ROW_REQUEST, 11'd0, CMD_QUERY, 10'd1023, 10'd1023, 32'd0, 1'b0, 32'd0, STATUS_OK},
      '{ROW_REQUEST, 11'd0, CMD_QUERY, 10'd0, 10'd1023, 32'd0, 1'b0, 32'd0, STATUS_OK},
      // A range whose start lies past its end is rejected.
      '{ROW_REQUEST, 11'd0, CMD_QUERY, 10'd5, 10'd4, 32'd0, 1'b1, 32'd0, STATUS_INVALID},
      // A query across the midpoint of the root, and a rewrite with the same value.
      '{ROW_REQUEST, 11'd0, CMD_UPDATE, 10'd512, 10'd0, 32'h1234_5678, 1'b0, 32'd0, STATUS_OK},
      '{ROW_REQUEST, 11'd0, CMD_QUERY, 10'd511, 10'd512, 32'd0, 1'b0, 32'd0, STATUS_OK},
      '{ROW_REQUEST, 11'd0, CMD_UPDATE, 10'd512, 10'd0, 32'h1234_5678, 1'b0, 32'd0, STATUS_OK},
      '{ROW_REQUEST, 11'd0, CMD_QUERY, 10'd0, 10'd1023, 32'd0, 1'b0, 32'd0, STATUS_OK},
      // A shorter length makes the upper elements unreachable but keeps their values.
      '{ROW_LENGTH, 11'd100, CMD_QUERY, 10'd0, 10'd0, 32'd0, 1'b0, 32'd0, STATUS_OK},
      '{ROW_REQUEST, 11'd0, CMD_UPDATE, 10'd100, 10'd0, 32'd7, 1'b1, 32'd0, STATUS_INVALID},
      '{ROW_REQUEST, 11'd0, CMD_QUERY, 10'd0, 10'd100, 32'd0, 1'b1, 32'd0, STATUS_INVALID},
      '{ROW_REQUEST, 11'd0, CMD_QUERY, 10'd0, 10'd99, 32'd0, 1'b0, 32'd0, STATUS_OK},
      // With a length of zero every request is rejected.
      '{ROW_LENGTH, 11'd0, CMD_QUERY, 10'd0, 10'd0, 32'd0, 1'b0, 32'd0, STATUS_OK},
      '{ROW_REQUEST, 11'd0, CMD_UPDATE, 10'd0, 10'd0, 32'd9, 1'b1, 32'd0, STATUS_INVALID},
      '{ROW_REQUEST, 11'd0, CMD_QUERY, 10'd0, 10'd0, 32'd0, 1'b1, 32'd0, STATUS_INVALID},
      // A length beyond the leaf count saturates, so the hidden elements come back.
      '{ROW_LENGTH, 11'd2047, CMD_QUERY, 10'd0, 10'd0, 32'd0, 1'b0, 32'd0, STATUS_OK},
      '{ROW_REQUEST, 11'd0, CMD_QUERY, 10'd0, 10'd1023, 32'd0, 1'b0, 32'd0, STATUS_OK},
      '{ROW_REQUEST, 11'd0, CMD_UPDATE, 10'd1023, 10'd1023, 32'd5, 1'b0, 32'd0, STATUS_OK},
      '{ROW_REQUEST, 11'd0, CMD_QUERY, 10'd1023, 10'd1023, 32'd0, 1'b0, 32'd0, STATUS_OK},
      // The smallest useful length holds a single element.
      '{ROW_LENGTH, 11'd1, CMD_QUERY, 10'd0, 10'd0, 32'd0, 1'b0, 32'd0, STATUS_OK},
      '{ROW_REQUEST, 11'd0, CMD_QUERY, 10'd0, 10'd0, 32'd0, 1'b0, 32'd0, STATUS_OK},
      '{ROW_REQUEST, 11'd0, CMD_UPDATE, 10'd1, 10'd0, 32'd3, 1'b1, 32'd0, STATUS_INVALID},
      '{ROW_REQUEST, 11'd0, CMD_QUERY, 10'd1023, 10'd0, 32'd0, 1'b1, 32'd0, STATUS_INVALID}
   };

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_command;
   logic [LEAF_BITS-1:0]     req_range_start;
   logic [LEAF_BITS-1:0]     req_range_end;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [DATA_W-1:0] rsp_sum;
   logic                     rsp_status;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [LEN_W-1:0]         csr_active_length;

   // Model state. Every tree node always equals the wrapping sum of the elements below it,
   // so the element values and the programmed length are all that prediction needs.
   logic [DATA_W-1:0] element_value [LEAVES];
   logic [LEN_W-1:0]  model_length;
   range_result_type  pending_results [$];
   range_result_type  oldest;

   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  hold_cycles;
   bit  no_idle;

   segment_tree_range_sum_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_range_start   (req_range_start),
      .req_range_end     (req_range_end),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sum           (rsp_sum),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_active_length (csr_active_length)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Applies one request to the model and returns the response it must produce.
   // An update simply replaces the element; the core's path adjustment by the
   // difference from the old leaf amounts to the same sums.
   function automatic range_result_type apply_range_request(logic command,
                                                             logic [9:0] first_idx,
                                                             logic [9:0] last_idx,
                                                             logic [DATA_W-1:0] value);
      int unsigned      span;
      logic [31:0]      total;
      range_result_type result;
      span          = (model_length > LEN_MAX) ? LEAVES : model_length;
      result.sum    = '0;
      result.status = STATUS_OK;
      if (command == CMD_UPDATE) begin
         if (first_idx >= span) result.status = STATUS_INVALID;
         else element_value[first_idx] = value;
      end else if (last_idx >= span || first_idx > last_idx) begin
         result.status = STATUS_INVALID;
      end else begin
         total = '0;
         for (int k = int'(first_idx); k <= int'(last_idx); k++)
            total += element_value[k[LEAF_BITS-1:0]];
         result.sum = total;
      end
      return result;
   endfunction

   // Presents one request after a random gap (none while no_idle is set) and returns in the
   // time step of its acceptance, with valid still high: the caller either presents the next
   // request or lowers valid right away, so valid is never lowered and raised in the same step.
   task automatic issue_request(logic command, logic [9:0] first_idx, logic [9:0] last_idx,
                                logic [DATA_W-1:0] value, logic typed,
                                range_result_type typed_result);
      int               gap;
      range_result_type predicted;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= command;
      req_range_start <= first_idx;
      req_range_end   <= last_idx;
      req_value       <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_range_request(command, first_idx, last_idx, value);
      pending_results.push_back(typed ? typed_result : predicted);
   endtask

   // Holds off new requests until every expected response has come back.
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The length register is only written while the core is idle.
   task automatic program_length(logic [LEN_W-1:0] length);
      wait_for_responses();
      csr_valid         <= 1'b1;
      csr_active_length <= length;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid    <= 1'b0;
      model_length  = length;
   endtask

   // Stimulus: reset, the directed script, then random phases at different lengths.
   initial begin
      int               span;
      int               pick;
      logic             command;
      logic [9:0]       first_idx;
      logic [9:0]       last_idx;
      logic [31:0]      value;
      logic [LEN_W-1:0] length;
      script_row_type   row;

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_command       = CMD_UPDATE;
      req_range_start   = '0;
      req_range_end     = '0;
      req_value         = '0;
      csr_valid         = 1'b0;
      csr_active_length = LEN_RESET;
      model_length      = LEN_RESET;
      no_idle           = 1'b0;
      foreach (element_value[k]) element_value[k] = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < SCRIPT_ROWS; r++) begin
         row = SCRIPT[r];
         if (row.kind == ROW_LENGTH)
            program_length(row.length);
         else
            issue_request(row.command, row.first_idx, row.last_idx, row.value, row.typed,
                          '{row.exp_sum, row.exp_status});
      end

      // Random phases. The lengths cover the full span, tiny spans, the saturated case and
      // one random span. Most requests use in-range indices so that updates really land and
      // queries return real sums; the rest are unconstrained and mostly rejected.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0:       length = LEN_MAX;
            1:       length = 11'd3;
            2:       length = 11'd2047;
            3:       length = LEN_W'($urandom_range(2, LEAVES - 1));
            4:       length = 11'd1;
            default: length = LEN_MAX;
         endcase
         program_length(length);
         span = (length > LEN_MAX) ? LEAVES : length;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // A burst with no gaps and no stalls, and once per phase a full drain.
            no_idle = (k >= 40 && k < 70);
            if (k == 80) wait_for_responses();
            command = ($urandom_range(0, 99) < 45) ? CMD_UPDATE : CMD_QUERY;
            if ($urandom_range(0, 99) < 85) begin
               first_idx = 10'($urandom_range(0, span - 1));
               if ($urandom_range(0, 3) == 0)
                  last_idx = 10'(first_idx + $urandom_range(0, 3));
               else
                  last_idx = 10'($urandom_range(first_idx, span - 1));
               if (last_idx >= span) last_idx = 10'(span - 1);
            end else begin
               first_idx = 10'($urandom);
               last_idx  = 10'($urandom);
            end
            pick = $urandom_range(0, 9);
            case (pick)
               0:       value = 32'h7fff_ffff;
               1:       value = 32'h8000_0000;
               2:       value = 32'hffff_ffff;
               3:       value = $urandom_range(0, 15);
               default: value = $urandom;
            endcase
            issue_request(command, first_idx, last_idx, value, 1'b0, '0);
         end
      end
      no_idle = 1'b0;

      wait_for_responses();
      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS segment_tree_range_sum_core");
      else
         $display("FAIL segment_tree_range_sum_core");
      $finish;
   end

   // Response side: check every accepted response against the oldest expectation,
   // then, outside a no-idle burst, stall for a random time before taking the next one.
   always @(posedge clock) begin
      if (reset) begin
         hold_cycles = 0;
         rsp_stall  <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("response with no request pending: sum %0d status %0d",
                      rsp_sum, rsp_status);
               mismatch_count++;
            end else begin
               oldest = pending_results.pop_front();
               if (rsp_sum !== oldest.sum) begin
                  $error("sum: expected %0d, actual %0d", $signed(oldest.sum), rsp_sum);
                  mismatch_count++;
               end
               if (rsp_status !== oldest.status) begin
                  $error("status: expected %0d, actual %0d", oldest.status, rsp_status);
                  mismatch_count++;
               end
            end
            hold_cycles = no_idle ? 0 : $urandom_range(0, 3);
         end else if (rsp_valid && hold_cycles > 0) begin
            hold_cycles--;
         end
         rsp_stall <= (hold_cycles > 0);
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL segment_tree_range_sum_core");
         $finish;
      end
   end

endmodule

>>> filelist.f
rtl/strs_pkg.sv
rtl/strs_mem.sv
rtl/segment_tree_range_sum_core.sv
tb/tb_segment_tree_range_sum_core.sv
